// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants for the heap sort engine
// Sequencer state encoding and key width.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_NODE,
        S_HOLD,
        S_LEFT,
        S_RIGHT,
        S_CMP,
        S_PUT,
        S_X_ROOT,
        S_X_END,
        S_X_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/heap_sort_engine_top.sv =====
// ----------------------------------------------------------------------------
// heap_sort_engine_top: in-place heapsort of signed 32-bit keys
// Loading takes one key per cycle. On the request marked tlast the stored
// keys are heap sorted (max-heap, ascending) in one key memory with one read
// and one write port and registered read, then streamed out in order; m_tlast
// marks the final key. Sorting: each sift-down reads its node, then for each
//   heap level reads both children and compares; each read waits on the
//   registered memory output. Each output key is read, then held until m_tready.
// Reset (aresetn low, synchronous) empties the store and returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [hse_pkg::KEY_W-1:0] s_tdata,   // [31:0] key
    input  wire logic                     s_tlast,    // last_item
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [hse_pkg::KEY_W-1:0]     m_tdata,    // [31:0] sorted_key
    output logic                          m_tlast     // last_key
);

    import hse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // key memory
    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    wr_en;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] heap_reg, heap_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] build_reg, build_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic          right_ok_reg, right_ok_next;
    logic [CW:0]   child_idx_reg, child_idx_next;
    logic signed [KEY_W-1:0] hold_reg, hold_next;
    logic signed [KEY_W-1:0] child_reg, child_next;
    logic [KEY_W-1:0]        out_key_reg, out_key_next;
    logic                    out_last_reg, out_last_next;

    logic          s_fire;
    logic          m_fire;
    logic [CW-1:0] load_n;
    logic [CW:0]   left_idx;
    logic [CW:0]   right_idx;
    logic [CW:0]   heap_ext;
    logic          left_in;
    logic          right_in;
    logic          pick_right;
    logic signed [KEY_W-1:0] big_val;
    logic [CW:0]   big_idx;
    logic [CW-1:0] heap_dec;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign load_n    = (count_reg < DEPTH_C) ? count_reg + ONE_C : count_reg;
    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};
    assign heap_ext  = {1'b0, heap_reg};
    assign left_in   = left_idx <= heap_ext;
    assign right_in  = right_idx <= heap_ext;
    assign pick_right = right_ok_reg && (child_reg < rd_data_reg);
    assign big_val   = pick_right ? rd_data_reg : child_reg;
    assign big_idx   = pick_right ? child_idx_reg + (CW+1)'(1) : child_idx_reg;
    assign heap_dec  = heap_reg - ONE_C;

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_EMIT_WAIT);
    assign m_tdata  = out_key_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = (load_n > ONE_C) ? S_NODE : S_EMIT_RD;
                end
            end
            S_NODE:  state_next = S_HOLD;
            S_HOLD:  state_next = S_LEFT;
            S_LEFT:  state_next = left_in ? S_RIGHT : S_PUT;
            S_RIGHT: state_next = S_CMP;
            S_CMP:   state_next = (hold_reg < big_val) ? S_LEFT : S_PUT;
            S_PUT: begin
                if (build_reg > ONE_C) begin
                    state_next = S_NODE;
                end else if (build_reg == ONE_C || heap_reg > ONE_C) begin
                    state_next = S_X_ROOT;
                end else begin
                    state_next = S_EMIT_RD;
                end
            end
            S_X_ROOT:  state_next = S_X_END;
            S_X_END:   state_next = S_X_SWAP;
            S_X_SWAP:  state_next = S_LEFT;
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD: state_next = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (m_fire) begin
                    state_next = out_last_reg ? S_LOAD : S_EMIT_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        count_next     = count_reg;
        heap_next      = heap_reg;
        pos_next       = pos_reg;
        build_next     = build_reg;
        emit_next      = emit_reg;
        right_ok_next  = right_ok_reg;
        child_idx_next = child_idx_reg;
        hold_next      = hold_reg;
        child_next     = child_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_data        = hold_reg;
        wr_en          = 1'b0;
        case (state_reg)
            S_LOAD: begin
                wr_addr = count_reg[AW-1:0];
                wr_data = s_tdata;
                if (s_fire) begin
                    // drop keys past a full store
                    wr_en      = count_reg < DEPTH_C;
                    count_next = load_n;
                    if (s_tlast) begin
                        heap_next  = load_n;
                        build_next = load_n >> 1;
                        pos_next   = load_n >> 1;
                        emit_next  = '0;
                    end
                end
            end
            S_NODE: begin
                rd_addr = pos_reg[AW-1:0] - AW'(1);
            end
            S_HOLD: begin
                hold_next = rd_data_reg;
            end
            S_LEFT: begin
                rd_addr = left_idx[AW-1:0] - AW'(1);
            end
            S_RIGHT: begin
                rd_addr        = right_idx[AW-1:0] - AW'(1);
                child_next     = rd_data_reg;
                child_idx_next = left_idx;
                right_ok_next  = right_in;
            end
            S_CMP: begin
                wr_addr = pos_reg[AW-1:0] - AW'(1);
                wr_data = big_val;
                if (hold_reg < big_val) begin
                    // move the larger child up, keep sifting the held key
                    wr_en    = 1'b1;
                    pos_next = big_idx[CW-1:0];
                end
            end
            S_PUT: begin
                wr_addr = pos_reg[AW-1:0] - AW'(1);
                wr_data = hold_reg;
                wr_en   = 1'b1;
                if (build_reg > ONE_C) begin
                    build_next = build_reg - ONE_C;
                    pos_next   = build_reg - ONE_C;
                end else if (build_reg == ONE_C) begin
                    build_next = '0;
                end
            end
            S_X_ROOT: begin
                rd_addr = '0;
            end
            S_X_END: begin
                rd_addr    = heap_dec[AW-1:0];
                child_next = rd_data_reg;
            end
            S_X_SWAP: begin
                // root goes to the heap end, old end key sifts from the root
                wr_addr   = heap_dec[AW-1:0];
                wr_data   = child_reg;
                wr_en     = 1'b1;
                hold_next = rd_data_reg;
                heap_next = heap_dec;
                pos_next  = ONE_C;
            end
            S_EMIT_RD: begin
                rd_addr = emit_reg[AW-1:0];
            end
            S_EMIT_LD: begin
                out_key_next  = rd_data_reg;
                out_last_next = (emit_reg + ONE_C) == count_reg;
            end
            S_EMIT_WAIT: begin
                if (m_fire) begin
                    emit_next = emit_reg + ONE_C;
                    if (out_last_reg) begin
                        count_next = '0;
                        heap_next  = '0;
                    end
                end
            end
            default: begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            heap_reg     <= '0;
            pos_reg      <= '0;
            build_reg    <= '0;
            emit_reg     <= '0;
            right_ok_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_reg     <= heap_next;
            pos_reg      <= pos_next;
            build_reg    <= build_next;
            emit_reg     <= emit_next;
            right_ok_reg <= right_ok_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        child_idx_reg <= child_idx_next;
        hold_reg      <= hold_next;
        child_reg     <= child_next;
        out_key_reg   <= out_key_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and emit active together");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("element count exceeds depth");

    a_heap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_reg <= count_reg)
        else $error("heap larger than loaded set");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> emit_reg < count_reg)
        else $error("emit index past loaded set");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == '0))
        else $error("store not emptied after final key");

endmodule

`default_nettype wire
